/* rtl/core/rpd_pkg.sv */
package rpd_pkg;

  localparam int unsigned PinW      = 3;
  localparam int unsigned PinCount  = 8;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned CcW       = 4;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CmpW      = 5;

  localparam logic [CcW-1:0]   ChannelCountRst  = 4'd8;
  localparam logic [TimeW-1:0] SyncThresholdRst = 16'd3000;

  typedef enum logic {
    MODE_PWM = 1'b0,
    MODE_PPM = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE           = 2'd0,
    CFG_CHANNEL_COUNT  = 2'd1,
    CFG_SYNC_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PinW-1:0]  pin;
    logic             level;
    logic [TimeW-1:0] time_us;
  } in_t;

  typedef struct packed {
    logic [PinW-1:0]  channel;
    logic [TimeW-1:0] width_us;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

/* rtl/core/rpd_pwm_unit.sv */
module rpd_pwm_unit #(
  parameter int unsigned MaxChannels = 8,
  parameter int unsigned CntW        = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  rpd_pkg::in_t      req_i,
  input  logic [CntW-1:0]   count_i,
  output rpd_pkg::res_t     res_o
);

  localparam int unsigned Depth = (MaxChannels < rpd_pkg::PinCount) ?
                                  MaxChannels : rpd_pkg::PinCount;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [rpd_pkg::TimeW-1:0] rise_time_q [Depth];
  logic [Depth-1:0]          last_level_q;

  logic [IdxW-1:0]           idx;
  logic                      in_use;
  logic                      change;
  logic                      upd;

  assign idx    = req_i.pin[IdxW-1:0];
  assign in_use = {{(rpd_pkg::CmpW-rpd_pkg::PinW){1'b0}}, req_i.pin}
                  < rpd_pkg::CmpW'(count_i);
  assign change = in_use && (last_level_q[idx] != req_i.level);
  assign upd    = en_i && change;

  assign res_o.valid         = change && !req_i.level;
  assign res_o.data.channel  = req_i.pin;
  assign res_o.data.width_us = req_i.time_us - rise_time_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= '0;
    end else if (upd) begin
      last_level_q[idx] <= req_i.level;
    end
  end

  // rise time per pin
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (upd && req_i.level && (idx == IdxW'(i))) begin
        rise_time_q[i] <= req_i.time_us;
      end
    end
  end

endmodule

/* rtl/core/rpd_ppm_unit.sv */
module rpd_ppm_unit #(
  parameter int unsigned MaxChannels = 8,
  parameter int unsigned CntW        = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  rpd_pkg::in_t              req_i,
  input  logic [CntW-1:0]           count_i,
  input  logic [rpd_pkg::TimeW-1:0] sync_threshold_i,
  output rpd_pkg::res_t             res_o
);

  localparam int unsigned SlotW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  logic [rpd_pkg::TimeW-1:0] last_rise_q;
  logic                      started_q;
  logic [SlotW-1:0]          slot_q;
  logic [SlotW-1:0]          slot_d;

  logic                      hit;
  logic [rpd_pkg::TimeW-1:0] width;
  logic [rpd_pkg::CmpW-1:0]  slot_inc;

  assign hit      = (req_i.pin == '0) && req_i.level;
  assign width    = req_i.time_us - last_rise_q;
  assign slot_inc = rpd_pkg::CmpW'(slot_q) + rpd_pkg::CmpW'(1);

  // wrap after the last channel or on a sync gap
  always_comb begin
    if ((slot_inc >= rpd_pkg::CmpW'(count_i)) || (width > sync_threshold_i)) begin
      slot_d = '0;
    end else begin
      slot_d = SlotW'(slot_inc);
    end
  end

  assign res_o.valid         = hit && started_q;
  assign res_o.data.channel  = rpd_pkg::PinW'(slot_q);
  assign res_o.data.width_us = width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      slot_q    <= '0;
    end else if (en_i && hit) begin
      started_q <= 1'b1;
      if (started_q) begin
        slot_q <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && hit) begin
      last_rise_q <= req_i.time_us;
    end
  end

endmodule

/* rtl/core/rc_pwm_ppm_pulse_decoder.sv */
// RC receiver pulse decoder, PWM per pin or PPM on pin 0.
// Input channel: in_valid_i / in_ready_o carry pin level requests, each with
// a 16-bit microsecond timestamp. Output channel: out_valid_o / out_ready_i
// carry measured pulse widths with their channel number. A request yields
// zero or one result.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 mode, 1 channel count, 2 sync threshold); write only
// while the decoder is idle.
// Path: an accepted request is held in the input register, then decoded
// into the result register.
// Throughput: one request per cycle unless a held result stalls, set by
// the combinational subtract and compare between the two registers.
// Reset: mode PWM, 8 channels, sync threshold 3000, all pin levels low,
// PPM tracking restarted; both channels come up empty.
// Stall: while out_ready_i is low and a result is held, the input register
// keeps its request and in_ready_o drops once it is full.
module rc_pwm_ppm_pulse_decoder #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rpd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rpd_pkg::in_t                in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rpd_pkg::out_t               out_req_o
);

  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);

  rpd_pkg::mode_e            mode_q;
  logic [rpd_pkg::CcW-1:0]   channel_count_q;
  logic [rpd_pkg::TimeW-1:0] sync_threshold_q;

  logic                      in_valid_q;
  rpd_pkg::in_t              in_req_q;
  logic                      out_valid_q;
  rpd_pkg::out_t             out_req_q;

  logic [rpd_pkg::CmpW-1:0]  cc_ext;
  logic [CntW-1:0]           count;
  logic                      advance;
  rpd_pkg::res_t             pwm_res;
  rpd_pkg::res_t             ppm_res;
  rpd_pkg::res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= rpd_pkg::MODE_PWM;
      channel_count_q  <= rpd_pkg::ChannelCountRst;
      sync_threshold_q <= rpd_pkg::SyncThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpd_pkg::CFG_MODE:           mode_q <= rpd_pkg::mode_e'(cfg_data_i[0]);
        rpd_pkg::CFG_CHANNEL_COUNT:  channel_count_q <= cfg_data_i[rpd_pkg::CcW-1:0];
        rpd_pkg::CFG_SYNC_THRESHOLD: sync_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp channel count to 1..MAX_CHANNELS
  assign cc_ext = {1'b0, channel_count_q};
  always_comb begin
    priority if (cc_ext == '0) begin
      count = CntW'(1);
    end else if (cc_ext > rpd_pkg::CmpW'(MAX_CHANNELS)) begin
      count = CntW'(MAX_CHANNELS);
    end else begin
      count = CntW'(cc_ext);
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  rpd_pwm_unit #(
    .MaxChannels (MAX_CHANNELS),
    .CntW        (CntW)
  ) u_pwm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance && (mode_q == rpd_pkg::MODE_PWM)),
    .req_i   (in_req_q),
    .count_i (count),
    .res_o   (pwm_res)
  );

  rpd_ppm_unit #(
    .MaxChannels (MAX_CHANNELS),
    .CntW        (CntW)
  ) u_ppm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance && (mode_q == rpd_pkg::MODE_PPM)),
    .req_i            (in_req_q),
    .count_i          (count),
    .sync_threshold_i (sync_threshold_q),
    .res_o            (ppm_res)
  );

  assign res = (mode_q == rpd_pkg::MODE_PPM) ? ppm_res : pwm_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_req_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

/* dv/tb_rc_pwm_ppm_pulse_decoder.sv */
`timescale 1ns / 100ps

module tb_rc_pwm_ppm_pulse_decoder;

  localparam int unsigned MaxChannels  = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 800;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned SettleCycles = 4;

  class pulse_scoreboard;
    rpd_pkg::mode_e                mode;
    logic [rpd_pkg::CcW-1:0]       chan_count;
    logic [rpd_pkg::TimeW-1:0]     sync_thr;
    logic [rpd_pkg::TimeW-1:0]     rise_at [rpd_pkg::PinCount];
    logic                          pin_level [rpd_pkg::PinCount];
    logic [rpd_pkg::TimeW-1:0]     frame_rise;
    logic                          frame_started;
    logic [rpd_pkg::PinW-1:0]      slot;
    rpd_pkg::out_t                 widths_due [$];
    int unsigned                   errors;

    function new();
      mode          = rpd_pkg::MODE_PWM;
      chan_count    = rpd_pkg::ChannelCountRst;
      sync_thr      = rpd_pkg::SyncThresholdRst;
      for (int i = 0; i < rpd_pkg::PinCount; i++) begin
        rise_at[i]   = '0;
        pin_level[i] = 1'b0;
      end
      frame_rise    = '0;
      frame_started = 1'b0;
      slot          = '0;
      errors        = 0;
    endfunction

    function void set_reg(rpd_pkg::cfg_idx_e idx, logic [rpd_pkg::CfgDataW-1:0] data);
      case (idx)
        rpd_pkg::CFG_MODE:           mode = rpd_pkg::mode_e'(data[0]);
        rpd_pkg::CFG_CHANNEL_COUNT:  chan_count = data[rpd_pkg::CcW-1:0];
        rpd_pkg::CFG_SYNC_THRESHOLD: sync_thr = data[rpd_pkg::TimeW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned used_channels();
      if (chan_count == 0) return 1;
      if (chan_count > MaxChannels) return MaxChannels;
      return 32'(chan_count);
    endfunction

    // returns 1 when the request changes state or yields a width
    function bit note_request(rpd_pkg::in_t req);
      int unsigned   count;
      rpd_pkg::out_t res;
      count = used_channels();
      if (mode == rpd_pkg::MODE_PWM) begin
        if (req.pin >= count || pin_level[req.pin] == req.level) return 1'b0;
        pin_level[req.pin] = req.level;
        if (req.level) begin
          rise_at[req.pin] = req.time_us;
          return 1'b1;
        end
        res.channel  = req.pin;
        res.width_us = req.time_us - rise_at[req.pin];
        widths_due.push_back(res);
        return 1'b1;
      end
      if (req.pin != 0 || !req.level) return 1'b0;
      if (!frame_started) begin
        frame_rise    = req.time_us;
        frame_started = 1'b1;
        return 1'b1;
      end
      res.channel  = slot;
      res.width_us = req.time_us - frame_rise;
      frame_rise   = req.time_us;
      widths_due.push_back(res);
      if (slot + 1 >= count || res.width_us > sync_thr) slot = '0;
      else slot = slot + 1'b1;
      return 1'b1;
    endfunction

    function void check_width(rpd_pkg::out_t got);
      rpd_pkg::out_t want;
      if (widths_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual channel %0d width %0d",
                 $time, got.channel, got.width_us);
        errors++;
        return;
      end
      want = widths_due.pop_front();
      if (got.channel !== want.channel) begin
        $display("%0t: channel mismatch, expected %0d actual %0d",
                 $time, want.channel, got.channel);
        errors++;
      end
      if (got.width_us !== want.width_us) begin
        $display("%0t: width_us mismatch, expected %0d actual %0d",
                 $time, want.width_us, got.width_us);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  rpd_pkg::cfg_idx_e            cfg_idx;
  logic [rpd_pkg::CfgDataW-1:0] cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  rpd_pkg::in_t                 in_req;
  logic                         out_valid;
  logic                         out_ready;
  rpd_pkg::out_t                out_req;

  pulse_scoreboard              sb = new();
  logic [rpd_pkg::TimeW-1:0]    now_us;
  int unsigned                  in_max_gap;
  int unsigned                  out_max_stall;
  int unsigned                  useful_reqs;
  int unsigned                  cycles;

  rc_pwm_ppm_pulse_decoder #(
    .MAX_CHANNELS(MaxChannels)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_req(input logic [rpd_pkg::PinW-1:0] pin, input logic level,
                          input logic [rpd_pkg::TimeW-1:0] stamp);
    int unsigned  gap;
    rpd_pkg::in_t req;
    gap         = $urandom_range(in_max_gap);
    req.pin     = pin;
    req.level   = level;
    req.time_us = stamp;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (sb.note_request(req)) useful_reqs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.widths_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input rpd_pkg::mode_e m, input logic [rpd_pkg::CcW-1:0] cc,
                           input logic [rpd_pkg::TimeW-1:0] thr);
    cfg_we   <= 1'b1;
    cfg_idx  <= rpd_pkg::CFG_MODE;
    cfg_data <= rpd_pkg::CfgDataW'(m);
    @(posedge clk);
    cfg_idx  <= rpd_pkg::CFG_CHANNEL_COUNT;
    cfg_data <= rpd_pkg::CfgDataW'(cc);
    @(posedge clk);
    cfg_idx  <= rpd_pkg::CFG_SYNC_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_reg(rpd_pkg::CFG_MODE, rpd_pkg::CfgDataW'(m));
    sb.set_reg(rpd_pkg::CFG_CHANNEL_COUNT, rpd_pkg::CfgDataW'(cc));
    sb.set_reg(rpd_pkg::CFG_SYNC_THRESHOLD, thr);
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned              start;
    int unsigned              pick;
    logic [rpd_pkg::PinW-1:0] pin;
    start = useful_reqs;
    while (useful_reqs - start < target) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // noise: any pin, any level, any time
        send_req(rpd_pkg::PinW'($urandom_range(7)), 1'($urandom_range(1)),
                 rpd_pkg::TimeW'($urandom_range(16'hFFFF)));
      end else if (sb.mode == rpd_pkg::MODE_PWM) begin
        now_us = rpd_pkg::TimeW'(now_us + $urandom_range(2500, 1));
        pin    = rpd_pkg::PinW'($urandom_range(sb.used_channels() - 1));
        send_req(pin, !sb.pin_level[pin], now_us);
      end else begin
        if ($urandom_range(9) == 0) begin
          now_us = rpd_pkg::TimeW'(now_us + $urandom_range(20000, 3000));
        end else begin
          now_us = rpd_pkg::TimeW'(now_us + $urandom_range(3500, 500));
        end
        send_req('0, 1'b1, now_us);
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int unsigned stall;
      stall = $urandom_range(out_max_stall);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_width(out_req);
    end
  end

  initial begin
    rpd_pkg::mode_e            m;
    logic [rpd_pkg::CcW-1:0]   cc;
    logic [rpd_pkg::TimeW-1:0] thr;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= rpd_pkg::CFG_MODE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_req        <= '0;
    now_us        = '0;
    useful_reqs   = 0;
    in_max_gap    = 3;
    out_max_stall = 3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // pwm: wrapping widths, unchanged levels, zero width
    configure(rpd_pkg::MODE_PWM, 4'd8, 16'd3000);
    send_req(3'd7, 1'b1, 16'hFFF0);
    send_req(3'd7, 1'b0, 16'h0010);
    send_req(3'd0, 1'b1, 16'h0000);
    send_req(3'd0, 1'b0, 16'hFFFF);
    send_req(3'd0, 1'b0, 16'h1234);
    send_req(3'd2, 1'b1, 16'h5555);
    send_req(3'd2, 1'b1, 16'h6000);
    send_req(3'd2, 1'b0, 16'h5555);
    drain();

    // channel count zero acts as one, pins beyond it ignored
    configure(rpd_pkg::MODE_PWM, 4'd0, 16'd3000);
    send_req(3'd1, 1'b1, 16'd100);
    send_req(3'd0, 1'b1, 16'd200);
    send_req(3'd0, 1'b0, 16'd1700);
    drain();

    // channel count above max clamps
    configure(rpd_pkg::MODE_PWM, 4'd15, 16'd3000);
    send_req(3'd7, 1'b1, 16'hAAAA);
    send_req(3'd7, 1'b0, 16'hFFFF);
    drain();

    // ppm: ignored reports, first rise, slot wrap, sync at and above threshold
    configure(rpd_pkg::MODE_PPM, 4'd3, 16'd3000);
    send_req(3'd1, 1'b1, 16'd50);
    send_req(3'd0, 1'b0, 16'd60);
    send_req(3'd0, 1'b1, 16'd100);
    send_req(3'd0, 1'b1, 16'd1100);
    send_req(3'd0, 1'b1, 16'd2100);
    send_req(3'd0, 1'b1, 16'd3100);
    send_req(3'd0, 1'b1, 16'd6100);
    send_req(3'd0, 1'b1, 16'd9101);
    send_req(3'd0, 1'b1, 16'd10101);
    send_req(3'd0, 1'b1, 16'd11101);
    drain();

    // slot past a shrunk channel count, max width at max threshold
    configure(rpd_pkg::MODE_PPM, 4'd2, 16'hFFFF);
    send_req(3'd0, 1'b1, 16'd12101);
    send_req(3'd0, 1'b1, 16'd12100);
    drain();

    now_us = 16'd12100;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        0: begin
          in_max_gap    = 0;
          out_max_stall = 12;
        end
        1: begin
          in_max_gap    = 12;
          out_max_stall = 0;
        end
        2: begin
          in_max_gap    = 0;
          out_max_stall = 0;
        end
        default: begin
          in_max_gap    = 12;
          out_max_stall = 12;
        end
      endcase
      m   = rpd_pkg::mode_e'(p[0]);
      cc  = (p == 5) ? 4'd15 : (p == 7) ? 4'd0 : 4'($urandom_range(15));
      thr = (p == 1) ? 16'd0 : (p == 3) ? 16'hFFFF : 16'($urandom_range(5000, 1000));
      configure(m, cc, thr);
      random_phase(RandomItems / PhaseCount);
      drain();
    end

    if (sb.errors == 0 && sb.widths_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
